### design/lz77_greedy_compressor_macros.svh
// assertion helpers, clocked on clock and disabled during reset
`ifndef LZ77_GREEDY_COMPRESSOR_MACROS_SVH
`define LZ77_GREEDY_COMPRESSOR_MACROS_SVH

`ifndef ASSERT_OFF
`define LZC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define LZC_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`else
`define LZC_ASSERT(lbl, prop, msg)
`define LZC_ASSERT_IMP(lbl, pre, post, msg)
`endif

`endif

### design/lzc_pkg.sv
package lzc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [8:0] distance;
      logic [7:0] match_length;
      logic [7:0] next_byte;
      logic       next_present;
      logic       final_triple;
   } rsp_word_type;

   // what a cell does with its candidate flag on a shift
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_CONT  = 2'd1;
   localparam logic [1:0] MODE_DROP  = 2'd2;

   typedef struct packed {
      logic       shift;
      logic       flush;
      logic [1:0] mode;
   } cell_ctl_type;

endpackage

### design/lzc_cell.sv
module lzc_cell
   import lzc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [7:0]   cur_byte,
   input  logic [7:0]   prev_byte,
   input  logic         prev_valid,
   output logic [7:0]   byte_ff,
   output logic         valid_ff,
   output logic         alive_ff
);

   logic eq;
   logic alive_in;

   assign eq = (byte_ff == cur_byte);

   always_comb begin
      case (ctl.mode)
         MODE_START: alive_in = valid_ff && eq;
         MODE_CONT:  alive_in = alive_ff && eq;
         MODE_DROP:  alive_in = 1'b0;
         default:    alive_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         alive_ff <= 1'b0;
      end else if (ctl.flush) begin
         valid_ff <= 1'b0;
         alive_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= prev_valid;
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= prev_byte;
      end
   end

endmodule

### design/lzc_tree.sv
module lzc_tree
   import lzc_pkg::*;
#(
   parameter int WINDOW = 256
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [WINDOW-1:0]          leaf_bits,
   output logic                       root_valid,
   output logic [$clog2(WINDOW)-1:0]  root_index
);

   localparam int IW = $clog2(WINDOW);
   localparam int P  = 1 << IW;
   localparam int NN = P - 1;

   logic [P-1:0]  pad;
   logic [NN-1:0] nv_ff;
   logic [IW-1:0] ni_ff [NN];

   assign pad = P'(leaf_bits);

   // heap order: node i has children 2i+1 and 2i+2, the right one is farther
   for (genvar i = 0; i < NN; i++) begin : g_node
      localparam int L = 2 * i + 1;
      if (L >= NN) begin : g_leaf
         localparam int J0 = L - NN;
         localparam int J1 = J0 + 1;
         always_ff @(posedge clock) begin
            if (reset) begin
               nv_ff[i] <= 1'b0;
            end else begin
               nv_ff[i] <= pad[J0] | pad[J1];
            end
         end
         always_ff @(posedge clock) begin
            ni_ff[i] <= pad[J1] ? IW'(J1) : IW'(J0);
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            if (reset) begin
               nv_ff[i] <= 1'b0;
            end else begin
               nv_ff[i] <= nv_ff[L] | nv_ff[L+1];
            end
         end
         always_ff @(posedge clock) begin
            ni_ff[i] <= nv_ff[L+1] ? ni_ff[L+1] : ni_ff[L];
         end
      end
   end

   assign root_valid = nv_ff[0];
   assign root_index = ni_ff[0];

endmodule

### design/lz77_greedy_compressor.sv
// Greedy LZ77 compressor over a WINDOW-byte history held in a row of cells, one
// cell per backward distance; each cell keeps its byte, a filled bit and a
// candidate flag, and passes its byte to the next distance on every accepted
// word. For one input word the cell row compares and shifts at the accepting
// edge, the registered tree then finds the farthest live candidate, and once
// it has settled the triple, if any, is decided and loaded into the output
// register, after which req_stall drops and the next word can be taken. While
// an earlier result still sits in the output register under rsp_stall, a word
// that closes a triple waits as well, and so does the input.
// After the word marked end_of_input the history and match state are cleared
// and the next word starts a new stream. No clearing pass follows reset.
`include "lz77_greedy_compressor_macros.svh"

module lz77_greedy_compressor
   import lzc_pkg::*;
#(
   parameter int WINDOW    = 256,
   parameter int MAX_MATCH = 255
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int IW = $clog2(WINDOW);
   localparam int DW = $clog2(WINDOW + 1);
   localparam int LW = $clog2(MAX_MATCH + 1);
   localparam int CW = $clog2(IW + 1);

   logic              accept;
   logic              act_ff;
   logic [CW-1:0]     cnt_ff;
   logic [LW-1:0]     len_ff;
   logic [LW-1:0]     len_in;
   logic [LW-1:0]     len_plus;
   logic [1:0]        mode_ff;
   logic [1:0]        mode_now;
   logic [7:0]        b_ff;
   logic              e_ff;
   logic [DW-1:0]     old_far_ff;
   logic [DW-1:0]     far_dist;
   logic              root_valid;
   logic [IW-1:0]     root_index;
   logic              done;
   logic              emit;
   logic              fire;
   logic              out_free;
   rsp_word_type      res;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;
   cell_ctl_type      ctl;
   logic              no_next;
   logic              no_next_ok;

   logic [7:0]        cell_byte [WINDOW];
   logic [WINDOW-1:0] cell_valid;
   logic [WINDOW-1:0] cell_alive;

   assign accept   = req_valid && !act_ff;
   assign req_stall = act_ff;
   assign done     = act_ff && (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = done && (!emit || out_free);
   assign far_dist = DW'(root_index) + DW'(1);
   assign len_plus = len_ff + LW'(1);

   always_comb begin
      if (len_ff == '0) begin
         mode_now = MODE_START;
      end else if (len_ff >= LW'(MAX_MATCH)) begin
         mode_now = MODE_DROP;
      end else begin
         mode_now = MODE_CONT;
      end
   end

   assign ctl.shift = accept;
   assign ctl.flush = fire && e_ff;
   assign ctl.mode  = mode_now;

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         lzc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .cur_byte   (req_word.data_byte),
            .prev_byte  (req_word.data_byte),
            .prev_valid (1'b1),
            .byte_ff    (cell_byte[k]),
            .valid_ff   (cell_valid[k]),
            .alive_ff   (cell_alive[k])
         );
      end else begin : g_body
         lzc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .cur_byte   (req_word.data_byte),
            .prev_byte  (cell_byte[k-1]),
            .prev_valid (cell_valid[k-1]),
            .byte_ff    (cell_byte[k]),
            .valid_ff   (cell_valid[k]),
            .alive_ff   (cell_alive[k])
         );
      end
   end

   lzc_tree #(
      .WINDOW (WINDOW)
   ) u_tree (
      .clock      (clock),
      .reset      (reset),
      .leaf_bits  (cell_alive),
      .root_valid (root_valid),
      .root_index (root_index)
   );

   // root_valid here says whether any candidate survived this word
   always_comb begin
      emit   = 1'b0;
      res    = '0;
      len_in = len_ff;
      case (mode_ff)
         MODE_START: begin
            if (!root_valid) begin
               emit             = 1'b1;
               res.next_byte    = b_ff;
               res.next_present = 1'b1;
               res.final_triple = e_ff;
               len_in           = '0;
            end else begin
               len_in = LW'(1);
               if (e_ff) begin
                  emit             = 1'b1;
                  res.distance     = 9'(far_dist);
                  res.match_length = 8'd1;
                  res.final_triple = 1'b1;
               end
            end
         end
         MODE_CONT: begin
            if (!root_valid) begin
               emit             = 1'b1;
               res.distance     = 9'(old_far_ff);
               res.match_length = 8'(len_ff);
               res.next_byte    = b_ff;
               res.next_present = 1'b1;
               res.final_triple = e_ff;
               len_in           = '0;
            end else begin
               len_in = len_plus;
               if (e_ff) begin
                  emit             = 1'b1;
                  res.distance     = 9'(far_dist);
                  res.match_length = 8'(len_plus);
                  res.final_triple = 1'b1;
               end
            end
         end
         MODE_DROP: begin
            emit             = 1'b1;
            res.distance     = 9'(old_far_ff);
            res.match_length = 8'(len_ff);
            res.next_byte    = b_ff;
            res.next_present = 1'b1;
            res.final_triple = e_ff;
            len_in           = '0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      if (e_ff) begin
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         cnt_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            act_ff <= 1'b1;
            cnt_ff <= CW'(IW);
         end else if (fire) begin
            act_ff <= 1'b0;
            len_ff <= len_in;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // the tree is settled at accept, so its root is the farthest before this word
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= mode_now;
         b_ff       <= req_word.data_byte;
         e_ff       <= req_word.end_of_input;
         old_far_ff <= far_dist;
      end
      if (fire && emit) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign no_next    = rsp_valid_ff && !rsp_word_ff.next_present;
   assign no_next_ok = rsp_word_ff.final_triple && (rsp_word_ff.next_byte == 8'd0);

   `LZC_ASSERT_IMP(a_accept_starts_wait, accept, ##1 (act_ff && cnt_ff == CW'(IW)), "no wait")
   `LZC_ASSERT(a_len_range, len_ff <= LW'(MAX_MATCH), "match length beyond maximum")
   `LZC_ASSERT_IMP(a_match_has_candidate, (!act_ff && len_ff != '0), root_valid, "match lost")
   `LZC_ASSERT_IMP(a_missing_next_is_final, no_next, no_next_ok, "missing next byte")

endmodule

### sim/tb_top.sv
module tb_top;
   import lzc_pkg::*;

   localparam int WIN          = 256;
   localparam int MAXLEN       = 255;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PAUSE_AT     = 600;
   localparam int QUIET_FROM   = 1000;
   localparam int QUIET_TO     = 1300;
   localparam int HOLD_AFTER   = 250;
   localparam int HOLD_CYCLES  = 400;

   // how a plan row gets its expectation
   localparam logic [1:0] ROW_PREDICTED = 2'd0;
   localparam logic [1:0] ROW_SILENT    = 2'd1;
   localparam logic [1:0] ROW_TRIPLE    = 2'd2;

   // byte patterns of the random streams
   localparam int GEN_NOISE    = 0;
   localparam int GEN_ALPHABET = 1;
   localparam int GEN_RUNS     = 2;
   localparam int GEN_COPY     = 3;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       closes;
      logic [1:0] kind;
      logic [8:0] want_dist;
      logic [7:0] want_len;
      logic [7:0] want_next;
      logic       want_present;
      logic       want_final;
   } plan_row_type;

   localparam plan_row_type DIRECTED [25] = '{
      '{8'h00, 1'b0, ROW_TRIPLE,    9'd0, 8'd0, 8'h00, 1'b1, 1'b0},
      '{8'hff, 1'b0, ROW_TRIPLE,    9'd0, 8'd0, 8'hff, 1'b1, 1'b0},
      '{8'h00, 1'b0, ROW_SILENT,    9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'hff, 1'b0, ROW_SILENT,    9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h55, 1'b0, ROW_TRIPLE,    9'd2, 8'd2, 8'h55, 1'b1, 1'b0},
      // stream ends on the first byte of a match
      '{8'h55, 1'b1, ROW_TRIPLE,    9'd1, 8'd1, 8'h00, 1'b0, 1'b1},
      // one-byte stream right after a stream end
      '{8'haa, 1'b1, ROW_TRIPLE,    9'd0, 8'd0, 8'haa, 1'b1, 1'b1},
      '{8'h33, 1'b0, ROW_TRIPLE,    9'd0, 8'd0, 8'h33, 1'b1, 1'b0},
      '{8'h33, 1'b0, ROW_SILENT,    9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h34, 1'b0, ROW_TRIPLE,    9'd1, 8'd1, 8'h34, 1'b1, 1'b0},
      // two candidates, farthest one has to survive
      '{8'h33, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h33, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h34, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h7e, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h7e, 1'b1, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      // overlapping run that ends inside the match
      '{8'h5a, 1'b0, ROW_TRIPLE,    9'd0, 8'd0, 8'h5a, 1'b1, 1'b0},
      '{8'h5a, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h5a, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h5a, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h5a, 1'b1, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      // final byte breaks the match
      '{8'hc3, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'hc3, 1'b0, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'h3c, 1'b1, ROW_PREDICTED, 9'd0, 8'd0, 8'h00, 1'b0, 1'b0},
      '{8'hff, 1'b1, ROW_TRIPLE,    9'd0, 8'd0, 8'hff, 1'b1, 1'b1},
      '{8'h00, 1'b1, ROW_TRIPLE,    9'd0, 8'd0, 8'h00, 1'b1, 1'b1}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   plan_row_type plan_q [$];
   rsp_word_type pending_triples [$];
   int           bytes_sent = 0;
   int           triples_seen = 0;
   int           mismatch_count = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;

   // predictor state
   logic [7:0]   hist_bytes [WIN];
   bit           live [WIN];
   int           run_len;
   int           fill;
   int           wr_pos;

   lz77_greedy_compressor #(.WINDOW(WIN), .MAX_MATCH(MAXLEN)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_row(plan_row_type r);
      plan_q.insert(plan_q.size(), r);
   endfunction

   function automatic void add_expected(rsp_word_type w);
      pending_triples.insert(pending_triples.size(), w);
   endfunction

   function automatic bit quiet_stretch();
      return bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO;
   endfunction

   function automatic logic [7:0] back_byte(int d);
      return hist_bytes[(wr_pos + WIN - d) % WIN];
   endfunction

   function automatic int farthest_live();
      int d;
      for (d = WIN; d >= 1; d--) begin
         if (live[d - 1]) return d;
      end
      return 0;
   endfunction

   task automatic clear_history();
      int d;
      for (d = 0; d < WIN; d++) begin
         hist_bytes[d] = 8'h00;
         live[d] = 1'b0;
      end
      run_len = 0;
      fill = 0;
      wr_pos = 0;
   endtask

   task automatic compress_byte(input req_word_type w, output bit got, output rsp_word_type t);
      logic [7:0] b;
      bit any;
      int d;
      int old_far;
      b = w.data_byte;
      any = 1'b0;
      got = 1'b0;
      t = '0;
      if (run_len == 0) begin
         for (d = 1; d <= WIN; d++) begin
            live[d - 1] = (d <= fill) && (back_byte(d) == b);
            any |= live[d - 1];
         end
         if (!any) begin
            got = 1'b1;
            t = '{9'd0, 8'd0, b, 1'b1, w.end_of_input};
         end else begin
            run_len = 1;
            if (w.end_of_input) begin
               got = 1'b1;
               t = '{9'(farthest_live()), 8'd1, 8'd0, 1'b0, 1'b1};
            end
         end
      end else if (run_len >= MAXLEN) begin
         // full length: this byte is taken as next byte without a compare
         got = 1'b1;
         t = '{9'(farthest_live()), 8'(run_len), b, 1'b1, w.end_of_input};
         for (d = 0; d < WIN; d++) live[d] = 1'b0;
         run_len = 0;
      end else begin
         old_far = farthest_live();
         for (d = 1; d <= WIN; d++) begin
            if (live[d - 1]) begin
               if (back_byte(d) == b) any = 1'b1;
               else live[d - 1] = 1'b0;
            end
         end
         if (!any) begin
            got = 1'b1;
            t = '{9'(old_far), 8'(run_len), b, 1'b1, w.end_of_input};
            run_len = 0;
         end else begin
            run_len++;
            if (w.end_of_input) begin
               got = 1'b1;
               t = '{9'(farthest_live()), 8'(run_len), 8'd0, 1'b0, 1'b1};
            end
         end
      end
      hist_bytes[wr_pos] = b;
      wr_pos = (wr_pos + 1) % WIN;
      if (fill < WIN) fill++;
      if (w.end_of_input) clear_history();
   endtask

   // sender
   always @(posedge clock) begin
      bit got;
      rsp_word_type guess;
      plan_row_type row;
      if (reset) begin
         req_valid <= 1'b0;
         bytes_sent = 0;
         clear_history();
      end else begin
         if (req_valid && !req_stall) begin
            row = plan_q[bytes_sent];
            compress_byte(req_word, got, guess);
            if (row.kind == ROW_TRIPLE) begin
               guess = '{row.want_dist, row.want_len, row.want_next, row.want_present,
                         row.want_final};
               add_expected(guess);
            end else if (row.kind == ROW_PREDICTED && got) begin
               add_expected(guess);
            end
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            // one pause until every expected word is back
            if (bytes_sent < plan_q.size()
                && !(bytes_sent == PAUSE_AT && pending_triples.size() != 0)
                && (quiet_stretch() || $urandom_range(99) >= 22)) begin
               row = plan_q[bytes_sent];
               req_valid <= 1'b1;
               req_word <= '{row.byte_in, row.closes};
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && triples_seen >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else if (quiet_stretch()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 22);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         triples_seen++;
         if (pending_triples.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected word: dist %0d len %0d next %02h present %0b final %0b",
                        rsp_word.distance, rsp_word.match_length, rsp_word.next_byte,
                        rsp_word.next_present, rsp_word.final_triple);
            mismatch_count++;
         end else begin
            want = pending_triples.pop_front();
            if (rsp_word.distance !== want.distance
                || rsp_word.match_length !== want.match_length
                || rsp_word.next_byte !== want.next_byte
                || rsp_word.next_present !== want.next_present
                || rsp_word.final_triple !== want.final_triple) begin
               if (mismatch_count < 10)
                  $display("word %0d: expected dist %0d len %0d next %02h present %0b final %0b,",
                           triples_seen, want.distance, want.match_length, want.next_byte,
                           want.next_present, want.final_triple,
                           " got dist %0d len %0d next %02h present %0b final %0b",
                           rsp_word.distance, rsp_word.match_length, rsp_word.next_byte,
                           rsp_word.next_present, rsp_word.final_triple);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int k;
      int pos;
      int n_len;
      int mode;
      int roll;
      int run_left;
      int copy_d;
      int copy_left;
      int alpha_n;
      int random_items;
      logic [7:0] b;
      logic [7:0] run_b;
      logic [7:0] alpha [4];
      logic [7:0] cur [$];
      plan_row_type row;
      for (k = 0; k < 25; k++) add_row(DIRECTED[k]);
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 70) n_len = $urandom_range(30, 1);
         else if (roll < 92) n_len = $urandom_range(150, 31);
         else n_len = $urandom_range(520, 257);
         if (n_len > RANDOM_ITEMS - random_items) n_len = RANDOM_ITEMS - random_items;
         roll = $urandom_range(99);
         if (roll < 15) mode = GEN_NOISE;
         else if (roll < 45) mode = GEN_ALPHABET;
         else if (roll < 70) mode = GEN_RUNS;
         else mode = GEN_COPY;
         // long streams lean on long runs to reach the length limit
         if (n_len > WIN && $urandom_range(1)) mode = GEN_RUNS;
         alpha_n = $urandom_range(4, 2);
         for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255));
         cur.delete();
         run_left = 0;
         copy_left = 0;
         copy_d = 1;
         for (pos = 0; pos < n_len; pos++) begin
            case (mode)
               GEN_NOISE: b = 8'($urandom_range(255));
               GEN_ALPHABET: b = alpha[$urandom_range(alpha_n - 1)];
               GEN_RUNS: begin
                  if (run_left == 0) begin
                     run_b = $urandom_range(1) ? alpha[0] : 8'($urandom_range(255));
                     if ($urandom_range(99) < 25) run_left = $urandom_range(300, 200);
                     else run_left = $urandom_range(8, 1);
                  end
                  b = run_b;
                  run_left--;
               end
               default: begin
                  // copy an earlier piece of this stream, now and then corrupted
                  if (copy_left == 0 && cur.size() != 0 && $urandom_range(99) < 80) begin
                     copy_d = $urandom_range(cur.size() < WIN ? cur.size() : WIN, 1);
                     copy_left = $urandom_range(40, 2);
                  end
                  if (copy_left > 0) begin
                     b = cur[cur.size() - copy_d];
                     copy_left--;
                     if ($urandom_range(99) < 3) b = 8'($urandom_range(255));
                  end else begin
                     b = alpha[$urandom_range(alpha_n - 1)];
                  end
               end
            endcase
            cur.insert(cur.size(), b);
            row = '0;
            row.byte_in = b;
            row.closes = (pos == n_len - 1);
            row.kind = ROW_PREDICTED;
            add_row(row);
         end
         random_items += n_len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (bytes_sent < plan_q.size() || pending_triples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_triples.size() == 0) begin
         $display("lz77_greedy_compressor: match");
      end else begin
         $display("lz77_greedy_compressor: mismatch");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("lz77_greedy_compressor: mismatch");
      $finish;
   end

endmodule
